@@ rtl/core/fcf_pkg.sv @@
// Shared constants, types and register codes of the clamped FIR filter.
package fcf_pkg;

	localparam int TAPS        = 9;
	localparam int SAMPLE_BITS = 16;
	localparam int MAX_FRAME   = 65536;

	localparam int COEF_BITS     = 16;
	localparam int COEF_FRAC     = 15;
	localparam int TAPS_PER_WORD = 4;
	localparam int HIST          = TAPS - 1;
	localparam int HALF          = (TAPS - 1) / 2;
	localparam int PROD_BITS     = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_BITS      = PROD_BITS + $clog2(TAPS);
	localparam int RES_BITS      = ACC_BITS - COEF_FRAC;
	localparam int FILL_BITS     = $clog2(HIST + 1);
	localparam int FIDX_BITS     = $clog2(MAX_FRAME + 1);
	localparam int POS_BITS      = 16;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 64;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_COEF_0_3 = 2'd0,
		REG_COEF_4_7 = 2'd1,
		REG_COEF_8   = 2'd2
	} cfg_reg_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [PROD_BITS-1:0]   prod_t;
	typedef logic signed [ACC_BITS-1:0]    acc_t;
	typedef logic [POS_BITS-1:0]           pos_t;

	typedef sample_t [TAPS-1:0] sample_vec_t;
	typedef coef_t   [TAPS-1:0] coef_vec_t;
	typedef prod_t   [TAPS-1:0] prod_vec_t;

	// Window stage to datapath: a request that yields a result.
	typedef struct packed {
		logic valid;
		pos_t position;
	} issue_t;

endpackage

@@ rtl/core/fcf_if.sv @@
// Stream and configuration channel interfaces of the clamped FIR filter.
interface fcf_sample_if;
	logic                   valid;
	logic                   ready;
	fcf_pkg::sample_t       sample;
	logic                   frame_start;

	modport source (output valid, sample, frame_start, input ready);
	modport sink (input valid, sample, frame_start, output ready);
endinterface

interface fcf_result_if;
	logic                   valid;
	logic                   ready;
	fcf_pkg::sample_t       filtered;
	fcf_pkg::pos_t          position;

	modport source (output valid, filtered, position, input ready);
	modport sink (input valid, filtered, position, output ready);
endinterface

interface fcf_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [fcf_pkg::CFG_IDX_BITS-1:0]     index;
	logic [fcf_pkg::CFG_DATA_BITS-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/fir9_clamped_filter.sv @@
// Top level of the streaming nine-tap clamped FIR filter.
// One sample request is taken per clock while the result side drains. A sample
// that completes a nine-sample window of its frame has its products loaded into
// the product register at the accepting edge, its sum in the sum register, and
// its result in the output register. The first and last four positions of
// a frame yield nothing, nor does any sample past the maximum frame length.
// Results carry the frame index of the window centre. samples.ready follows
// results.ready through the three stage valids, so it only drops when all three
// stages hold results behind a stalled output. The user must write coefficients
// through cfg (always ready) only while idle; the block does not enforce this.
module fir9_clamped_filter (
	input  logic          clk,
	input  logic          arst_n,
	fcf_sample_if.sink    samples,
	fcf_result_if.source  results,
	fcf_cfg_if.sink       cfg
);

	fcf_pkg::coef_vec_t    coefs;
	fcf_pkg::sample_vec_t  taps;
	fcf_pkg::issue_t       issue;
	logic                  issue_ready;
	logic                  accept;

	assign samples.ready = issue_ready;
	assign accept        = samples.valid && samples.ready;

	// coefficient registers
	fcf_coef_regs u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.coefs  (coefs)
	);

	// history window, fill count, frame index
	fcf_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.sample      (samples.sample),
		.frame_start (samples.frame_start),
		.taps        (taps),
		.issue       (issue)
	);

	// products -> sum -> round/clamp -> output register
	fcf_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.taps        (taps),
		.coefs       (coefs),
		.issue       (issue),
		.issue_ready (issue_ready),
		.results     (results)
	);

	// backpressure only comes from a held output
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> results.valid)
		else $error("input stalled with no result waiting");

	// results are only launched by accepted requests
	a_issue_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid |-> accept)
		else $error("result issued without an accepted request");

	// a new frame cannot complete a window on the following sample
	a_frame_start_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && samples.frame_start) |=> !issue.valid)
		else $error("result issued right after frame start");

endmodule

@@ rtl/core/fcf_coef_regs.sv @@
// Coefficient register file: three packed registers unpacked into per-tap values.
module fcf_coef_regs (
	input  logic                clk,
	input  logic                arst_n,
	fcf_cfg_if.sink             cfg,
	output fcf_pkg::coef_vec_t  coefs
);

	logic [fcf_pkg::CFG_DATA_BITS-1:0] coef_lo_q;
	logic [fcf_pkg::CFG_DATA_BITS-1:0] coef_hi_q;
	fcf_pkg::coef_t                    coef_last_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_lo_q   <= '0;
			coef_hi_q   <= '0;
			coef_last_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				fcf_pkg::REG_COEF_0_3: coef_lo_q <= cfg.data;
				fcf_pkg::REG_COEF_4_7: coef_hi_q <= cfg.data;
				fcf_pkg::REG_COEF_8: coef_last_q <= cfg.data[fcf_pkg::COEF_BITS-1:0];
				default: ;
			endcase
		end
	end

	// taps past the ninth have no register and read as zero
	for (genvar k = 0; k < fcf_pkg::TAPS; k++) begin : g_tap
		if (k < fcf_pkg::TAPS_PER_WORD) begin : g_lo
			assign coefs[k] = coef_lo_q[fcf_pkg::COEF_BITS*k +: fcf_pkg::COEF_BITS];
		end else if (k < 2 * fcf_pkg::TAPS_PER_WORD) begin : g_hi
			assign coefs[k] = coef_hi_q[fcf_pkg::COEF_BITS*(k - fcf_pkg::TAPS_PER_WORD)
				+: fcf_pkg::COEF_BITS];
		end else if (k == 2 * fcf_pkg::TAPS_PER_WORD) begin : g_last
			assign coefs[k] = coef_last_q;
		end else begin : g_zero
			assign coefs[k] = '0;
		end
	end

endmodule

@@ rtl/core/fcf_window.sv @@
// Sample history, fill count and frame index; decides which requests yield a result.
module fcf_window (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  fcf_pkg::sample_t      sample,
	input  logic                  frame_start,
	output fcf_pkg::sample_vec_t  taps,
	output fcf_pkg::issue_t       issue
);

	localparam logic [fcf_pkg::FILL_BITS-1:0] FILL_FULL = fcf_pkg::FILL_BITS'(fcf_pkg::HIST);
	localparam logic [fcf_pkg::FIDX_BITS-1:0] FIDX_MAX  = fcf_pkg::FIDX_BITS'(fcf_pkg::MAX_FRAME);
	localparam logic [fcf_pkg::FIDX_BITS-1:0] CENTER_LAG =
		fcf_pkg::FIDX_BITS'(fcf_pkg::HIST - fcf_pkg::HALF);

	fcf_pkg::sample_t                window_q [fcf_pkg::HIST];
	logic [fcf_pkg::FILL_BITS-1:0]   fill_q;
	logic [fcf_pkg::FIDX_BITS-1:0]   fidx_q;

	logic [fcf_pkg::FILL_BITS-1:0]   fill;
	logic [fcf_pkg::FIDX_BITS-1:0]   idx;
	logic                            full;
	logic                            in_range;

	// a frame start clears the history before this sample is taken
	assign fill     = frame_start ? '0 : fill_q;
	assign idx      = frame_start ? '0 : fidx_q;
	assign full     = (fill == FILL_FULL);
	assign in_range = (idx < FIDX_MAX);

	assign issue.valid    = accept && full && in_range;
	assign issue.position = fcf_pkg::POS_BITS'(idx - CENTER_LAG);

	for (genvar k = 0; k < fcf_pkg::HIST; k++) begin : g_taps
		assign taps[k] = window_q[k];
	end
	assign taps[fcf_pkg::HIST] = sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			fidx_q <= '0;
		end else if (accept) begin
			fill_q <= full ? fill : fill + 1'b1;
			fidx_q <= in_range ? idx + 1'b1 : idx;
		end
	end

	// plain shift line: once full it holds oldest..newest at 0..HIST-1
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < fcf_pkg::HIST - 1; k++) begin
				window_q[k] <= window_q[k+1];
			end
			window_q[fcf_pkg::HIST-1] <= sample;
		end
	end

endmodule

@@ rtl/core/fcf_mac.sv @@
// Multiply, sum and round/clamp datapath with output register.
module fcf_mac (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fcf_pkg::sample_vec_t  taps,
	input  fcf_pkg::coef_vec_t    coefs,
	input  fcf_pkg::issue_t       issue,
	output logic                  issue_ready,
	fcf_result_if.source          results
);

	localparam fcf_pkg::acc_t RND_HALF = fcf_pkg::ACC_BITS'(1) <<< (fcf_pkg::COEF_FRAC - 1);
	localparam logic signed [fcf_pkg::RES_BITS-1:0] Y_MAX =
		fcf_pkg::RES_BITS'((1 <<< (fcf_pkg::SAMPLE_BITS - 1)) - 1);
	localparam logic signed [fcf_pkg::RES_BITS-1:0] Y_MIN = -Y_MAX - fcf_pkg::RES_BITS'(1);

	fcf_pkg::prod_vec_t  prod_d;
	fcf_pkg::prod_vec_t  prod_s1;
	logic                valid_s1;
	fcf_pkg::pos_t       pos_s1;

	fcf_pkg::acc_t       acc_d;
	fcf_pkg::acc_t       acc_s2;
	logic                valid_s2;
	fcf_pkg::pos_t       pos_s2;

	fcf_pkg::acc_t                      rnd;
	logic signed [fcf_pkg::RES_BITS-1:0] y;
	fcf_pkg::sample_t                    y_sat;

	logic                out_valid_q;
	fcf_pkg::sample_t    filtered_q;
	fcf_pkg::pos_t       position_q;

	logic                out_free;
	logic                s2_ready;
	logic                s1_ready;

	assign out_free    = !out_valid_q || results.ready;
	assign s2_ready    = !valid_s2 || out_free;
	assign s1_ready    = !valid_s1 || s2_ready;
	assign issue_ready = s1_ready;

	always_comb begin
		for (int k = 0; k < fcf_pkg::TAPS; k++) begin
			prod_d[k] = fcf_pkg::PROD_BITS'($signed(taps[k]))
				* fcf_pkg::PROD_BITS'($signed(coefs[k]));
		end
	end

	always_comb begin
		acc_d = '0;
		for (int k = 0; k < fcf_pkg::TAPS; k++) begin
			acc_d = acc_d + fcf_pkg::ACC_BITS'($signed(prod_s1[k]));
		end
	end

	// round half up, then saturate to the sample range
	always_comb begin
		rnd = acc_s2 + RND_HALF;
		y   = $signed(rnd[fcf_pkg::ACC_BITS-1:fcf_pkg::COEF_FRAC]);
		if (y > Y_MAX) begin
			y_sat = fcf_pkg::SAMPLE_BITS'(Y_MAX);
		end else if (y < Y_MIN) begin
			y_sat = fcf_pkg::SAMPLE_BITS'(Y_MIN);
		end else begin
			y_sat = fcf_pkg::SAMPLE_BITS'(y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= issue.valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready) begin
			prod_s1 <= prod_d;
			pos_s1  <= issue.position;
		end
		if (s2_ready) begin
			acc_s2 <= acc_d;
			pos_s2 <= pos_s1;
		end
		if (out_free) begin
			filtered_q <= y_sat;
			position_q <= pos_s2;
		end
	end

	assign results.valid    = out_valid_q;
	assign results.filtered = filtered_q;
	assign results.position = position_q;

endmodule
